// ----- hw/rtl/tbcs_pkg.sv -----
// Shared types, constants and codes for the two-body collision stepper.
package tbcs_pkg;

  // Default word format: signed Q16.16
  localparam int WORD_BITS_DEFAULT     = 32;
  localparam int FRACTION_BITS_DEFAULT = 16;

  // Fixed field and register widths
  localparam int FIELD_BITS     = 32;
  localparam int MASS_BITS      = 10;
  localparam int DEN_BITS       = MASS_BITS + 1;
  localparam int TS_BITS        = 16;
  localparam int DIST_BITS      = 31;
  localparam int ELAS_BITS      = 17;
  localparam int COEF_BITS      = ELAS_BITS + 1;
  localparam int REG_FRAC       = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 31;

  // Width of the centre-of-mass numerator: two mass products and a carry
  localparam int NUM_BITS_DEFAULT = WORD_BITS_DEFAULT + MASS_BITS + 2;

  // Rounding offset for the Q0.16 scale products, and one in Q1.16
  localparam int                   ROUND_HALF = 1 << (REG_FRAC - 1);
  localparam logic [ELAS_BITS-1:0] E_ONE      = ELAS_BITS'(1 << REG_FRAC);

  // Reset magnitudes of position and velocity components, in whole units
  localparam int POS_RESET_MAG = 10;
  localparam int VEL_RESET_MAG = 5;

  // Item function codes
  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MASS_ONE         = 3'd0,
    REG_MASS_TWO         = 3'd1,
    REG_TIME_STEP        = 3'd2,
    REG_COLLIDE_DISTANCE = 3'd3,
    REG_ELASTICITY       = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [MASS_BITS-1:0] mass_one;
    logic [MASS_BITS-1:0] mass_two;
    logic [TS_BITS-1:0]   time_step;
    logic [DIST_BITS-1:0] collide_distance;
    logic [ELAS_BITS-1:0] elasticity;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mass_one:         MASS_BITS'(10),
    mass_two:         MASS_BITS'(50),
    time_step:        TS_BITS'(1114),
    collide_distance: DIST_BITS'(19661),
    elasticity:       E_ONE
  };

  // Input word
  typedef struct packed {
    logic                         func;
    logic                         body_select;
    logic signed [FIELD_BITS-1:0] load_pos_x;
    logic signed [FIELD_BITS-1:0] load_pos_y;
    logic signed [FIELD_BITS-1:0] load_vel_x;
    logic signed [FIELD_BITS-1:0] load_vel_y;
  } item_t;

  // Result word
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] first_pos_x;
    logic signed [FIELD_BITS-1:0] first_pos_y;
    logic signed [FIELD_BITS-1:0] second_pos_x;
    logic signed [FIELD_BITS-1:0] second_pos_y;
    logic signed [FIELD_BITS-1:0] first_vel_x;
    logic signed [FIELD_BITS-1:0] first_vel_y;
    logic signed [FIELD_BITS-1:0] second_vel_x;
    logic signed [FIELD_BITS-1:0] second_vel_y;
    logic                         collided;
  } result_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_ADV_MUL,
    S_ADV_UPD,
    S_DIST,
    S_DIST_CHK,
    S_SQ_Y,
    S_SQ_D,
    S_SQ_CMP,
    S_COM_A,
    S_COM_B,
    S_COM_SUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_VCM,
    S_RES,
    S_RES_MUL,
    S_RES_UPD,
    S_FINISH
  } state_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_LOAD,
    OP_ADV_MUL,
    OP_ADV_UPD,
    OP_DIST,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_D,
    OP_HIT,
    OP_COM_A,
    OP_COM_B,
    OP_COM_SUM,
    OP_DIV_START,
    OP_VCM,
    OP_RES,
    OP_RES_MUL,
    OP_RES_UPD,
    OP_OUT
  } dp_op_t;

  // Command from controller: operation and component select {body, axis}
  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;
  } cmd_t;

  // Status from datapath
  typedef struct packed {
    logic far;
    logic close;
    logic div_done;
  } dp_status_t;

endpackage

// ----- hw/rtl/tbcs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module tbcs_div #(
  parameter int NW = tbcs_pkg::NUM_BITS_DEFAULT,
  parameter int DW = tbcs_pkg::DEN_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic          fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quotient[NW-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == CW'(1)) |=> (done && !busy))
    else $error("divider did not finish after its last step");
`endif

endmodule

// ----- hw/rtl/tbcs_dp.sv -----
// Datapath: body state, shared scale multiplier, squarer and divider.
module tbcs_dp #(
  parameter int WORD_BITS     = tbcs_pkg::WORD_BITS_DEFAULT,
  parameter int FRACTION_BITS = tbcs_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tbcs_pkg::cmd_t       cmd,
  input  tbcs_pkg::item_t      item,
  input  tbcs_pkg::cfg_t       cfg,
  output tbcs_pkg::dp_status_t status,
  output tbcs_pkg::result_t    result
);

  import tbcs_pkg::*;

  localparam int SATW = ((WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS) + 3;
  localparam int PW   = WORD_BITS + COEF_BITS;
  localparam int RW   = PW - REG_FRAC;
  localparam int NUMW = WORD_BITS + MASS_BITS + 2;
  localparam int VW   = WORD_BITS + 1;
  localparam int SQW  = 2 * DIST_BITS;
  localparam int SQAW = SQW + 1;

  localparam logic signed [SATW-1:0] SAT_ONE = SATW'(1);
  localparam logic signed [SATW-1:0] WMAX    = (SAT_ONE <<< (WORD_BITS - 1)) - SAT_ONE;
  localparam logic signed [SATW-1:0] WMIN    = -WMAX - SAT_ONE;
  localparam logic signed [SATW-1:0] POS_MAG = SATW'(POS_RESET_MAG) <<< FRACTION_BITS;
  localparam logic signed [SATW-1:0] VEL_MAG = SATW'(VEL_RESET_MAG) <<< FRACTION_BITS;

  // Clamp a wide value to the signed word range
  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [SATW-1:0] a);
    if (a > WMAX) return WMAX[WORD_BITS-1:0];
    if (a < WMIN) return WMIN[WORD_BITS-1:0];
    return a[WORD_BITS-1:0];
  endfunction

  // Index 0 is x and 1 is y of the first body, 2 and 3 of the second
  logic signed [WORD_BITS-1:0] pos [4];
  logic signed [WORD_BITS-1:0] vel [4];
  logic                        hit;

  logic signed [WORD_BITS-1:0] pos_sel, vel_sel, diff, mul_a;
  logic signed [COEF_BITS-1:0] mul_b;
  logic signed [PW-1:0]        mul_p, prod, prod_rnd;
  logic signed [RW-1:0]        rnd;
  logic signed [NUMW-1:0]      acc, num;
  logic [NUMW-1:0]             num_mag, dividend, quotient;
  logic                        neg;
  logic signed [VW-1:0]        vcm;
  logic [MASS_BITS-1:0]        ma, mb;
  logic [DEN_BITS-1:0]         den;
  logic [ELAS_BITS-1:0]        e_lim;
  logic signed [SATW-1:0]      dx, dy, ax_full, ay_full;
  logic [DIST_BITS-1:0]        ax, ay, sq_op;
  logic                        far;
  logic [SQW-1:0]              sq_res, sq_prod;
  logic [SQAW-1:0]             sq_acc;
  logic                        div_start, div_done;

  // Register values as used: zero mass acts as one, elasticity caps at one
  assign ma    = (cfg.mass_one == '0) ? MASS_BITS'(1) : cfg.mass_one;
  assign mb    = (cfg.mass_two == '0) ? MASS_BITS'(1) : cfg.mass_two;
  assign den   = DEN_BITS'(ma) + DEN_BITS'(mb);
  assign e_lim = (cfg.elasticity > E_ONE) ? E_ONE : cfg.elasticity;

  assign pos_sel = pos[cmd.sel];
  assign vel_sel = vel[cmd.sel];

  // Pick operands of the shared scale multiplier
  always_comb begin
    mul_a = vel_sel;
    mul_b = COEF_BITS'(cfg.time_step);
    unique case (cmd.op) inside
      OP_COM_A: mul_b = COEF_BITS'(ma);
      OP_COM_B: mul_b = COEF_BITS'(mb);
      OP_RES_MUL: begin
        mul_a = diff;
        mul_b = COEF_BITS'(e_lim);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round a Q0.16 product half up back to word units
  assign prod_rnd = prod + PW'(ROUND_HALF);
  assign rnd      = $signed(prod_rnd[PW-1:REG_FRAC]);

  // Axis distances between the updated positions
  assign dx      = SATW'(pos[0]) - SATW'(pos[2]);
  assign dy      = SATW'(pos[1]) - SATW'(pos[3]);
  assign ax_full = (dx < 0) ? -dx : dx;
  assign ay_full = (dy < 0) ? -dy : dy;

  // Pick the squarer operand
  always_comb begin
    unique case (cmd.op) inside
      OP_SQ_Y: sq_op = ay;
      OP_SQ_D: sq_op = cfg.collide_distance;
      default: sq_op = ax;
    endcase
  end

  assign sq_res = SQW'(sq_op) * SQW'(sq_op);

  // Rounded centre-of-mass division: magnitude plus half the divisor
  assign num_mag   = num[NUMW-1] ? $unsigned(-num) : $unsigned(num);
  assign dividend  = num_mag + NUMW'(den >> 1);
  assign div_start = (cmd.op == OP_DIV_START);

  tbcs_div #(
    .NW(NUMW),
    .DW(DEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den),
    .quotient (quotient),
    .done     (div_done)
  );

  // Body state and collision flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= sat_word(-POS_MAG);
      pos[1] <= sat_word(POS_MAG);
      pos[2] <= sat_word(POS_MAG);
      pos[3] <= sat_word(POS_MAG);
      vel[0] <= sat_word(VEL_MAG);
      vel[1] <= sat_word(-VEL_MAG);
      vel[2] <= sat_word(-VEL_MAG);
      vel[3] <= sat_word(-VEL_MAG);
      hit    <= 1'b0;
    end else begin
      unique case (cmd.op) inside
        OP_START: hit <= 1'b0;
        OP_LOAD: begin
          pos[{item.body_select, 1'b0}] <= sat_word(SATW'(item.load_pos_x));
          pos[{item.body_select, 1'b1}] <= sat_word(SATW'(item.load_pos_y));
          vel[{item.body_select, 1'b0}] <= sat_word(SATW'(item.load_vel_x));
          vel[{item.body_select, 1'b1}] <= sat_word(SATW'(item.load_vel_y));
          hit <= 1'b0;
        end
        OP_ADV_UPD: pos[cmd.sel] <= sat_word(SATW'(pos_sel) + SATW'(rnd));
        OP_HIT:     hit <= 1'b1;
        OP_RES_UPD: vel[cmd.sel] <= sat_word(SATW'(vcm) - SATW'(rnd));
        default: ;
      endcase
    end
  end

  // Working registers and the result word
  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      OP_ADV_MUL, OP_COM_A, OP_RES_MUL: prod <= mul_p;
      OP_COM_B: begin
        acc  <= NUMW'(prod);
        prod <= mul_p;
      end
      OP_COM_SUM:   num <= acc + NUMW'(prod);
      OP_DIV_START: neg <= num[NUMW-1];
      OP_VCM: vcm <= neg ? -$signed(quotient[VW-1:0]) : $signed(quotient[VW-1:0]);
      OP_RES: diff <= sat_word(SATW'(vel_sel) - SATW'(vcm));
      OP_DIST: begin
        far <= (ax_full > $signed(SATW'(cfg.collide_distance))) ||
               (ay_full > $signed(SATW'(cfg.collide_distance)));
        ax  <= ax_full[DIST_BITS-1:0];
        ay  <= ay_full[DIST_BITS-1:0];
      end
      OP_SQ_X: sq_prod <= sq_res;
      OP_SQ_Y: begin
        sq_acc  <= SQAW'(sq_prod);
        sq_prod <= sq_res;
      end
      OP_SQ_D: begin
        sq_acc  <= sq_acc + SQAW'(sq_prod);
        sq_prod <= sq_res;
      end
      OP_OUT: begin
        result.first_pos_x  <= FIELD_BITS'(pos[0]);
        result.first_pos_y  <= FIELD_BITS'(pos[1]);
        result.second_pos_x <= FIELD_BITS'(pos[2]);
        result.second_pos_y <= FIELD_BITS'(pos[3]);
        result.first_vel_x  <= FIELD_BITS'(vel[0]);
        result.first_vel_y  <= FIELD_BITS'(vel[1]);
        result.second_vel_x <= FIELD_BITS'(vel[2]);
        result.second_vel_y <= FIELD_BITS'(vel[3]);
        result.collided     <= hit;
      end
      default: ;
    endcase
  end

  // Status back to the controller
  assign status.far      = far;
  assign status.close    = sq_acc <= SQAW'(sq_prod);
  assign status.div_done = div_done;

endmodule

// ----- hw/rtl/tbcs_ctrl.sv -----
// Controller: sequences one item through the datapath and owns the handshakes.
module tbcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_func,
  output logic                 item_stall,
  output logic                 result_valid,
  input  logic                 result_stall,
  input  tbcs_pkg::dp_status_t status,
  output tbcs_pkg::cmd_t       cmd
);

  import tbcs_pkg::*;

  state_t     state, state_next;
  logic [1:0] sel, sel_next;
  logic       result_valid_next;

  // State, component select and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sel          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      sel          <= sel_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state and datapath commands; sel is {body, axis}
  always_comb begin
    state_next        = state;
    sel_next          = sel;
    cmd.op            = OP_NONE;
    cmd.sel           = sel;
    item_stall        = 1'b1;
    result_valid_next = result_valid && result_stall;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item_func == FUNC_LOAD) begin
            cmd.op     = OP_LOAD;
            state_next = S_FINISH;
          end else begin
            cmd.op     = OP_START;
            sel_next   = '0;
            state_next = S_ADV_MUL;
          end
        end
      end
      S_ADV_MUL: begin
        cmd.op     = OP_ADV_MUL;
        state_next = S_ADV_UPD;
      end
      S_ADV_UPD: begin
        cmd.op   = OP_ADV_UPD;
        sel_next = sel + 2'd1;
        if (sel == 2'd3) begin
          state_next = S_DIST;
        end else begin
          state_next = S_ADV_MUL;
        end
      end
      S_DIST: begin
        cmd.op     = OP_DIST;
        state_next = S_DIST_CHK;
      end
      S_DIST_CHK: begin
        if (status.far) begin
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_SQ_X;
          state_next = S_SQ_Y;
        end
      end
      S_SQ_Y: begin
        cmd.op     = OP_SQ_Y;
        state_next = S_SQ_D;
      end
      S_SQ_D: begin
        cmd.op     = OP_SQ_D;
        state_next = S_SQ_CMP;
      end
      S_SQ_CMP: begin
        if (status.close) begin
          cmd.op     = OP_HIT;
          sel_next   = '0;
          state_next = S_COM_A;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_COM_A: begin
        cmd.op     = OP_COM_A;
        sel_next   = {1'b1, sel[0]};
        state_next = S_COM_B;
      end
      S_COM_B: begin
        cmd.op     = OP_COM_B;
        sel_next   = {1'b0, sel[0]};
        state_next = S_COM_SUM;
      end
      S_COM_SUM: begin
        cmd.op     = OP_COM_SUM;
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.op     = OP_DIV_START;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_VCM;
        end
      end
      S_VCM: begin
        cmd.op     = OP_VCM;
        state_next = S_RES;
      end
      S_RES: begin
        cmd.op     = OP_RES;
        state_next = S_RES_MUL;
      end
      S_RES_MUL: begin
        cmd.op     = OP_RES_MUL;
        state_next = S_RES_UPD;
      end
      S_RES_UPD: begin
        cmd.op = OP_RES_UPD;
        if (!sel[1]) begin
          sel_next   = {1'b1, sel[0]};
          state_next = S_RES;
        end else if (!sel[0]) begin
          sel_next   = {1'b0, 1'b1};
          state_next = S_COM_A;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the result register is free
        if (!(result_valid && result_stall)) begin
          cmd.op            = OP_OUT;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV_WAIT))
    else $error("divider finished outside the wait state");
  a_load_finish: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item_func == FUNC_LOAD) |=> (state == S_FINISH))
    else $error("load word did not go straight to finish");
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !result_stall) |=> (result_valid && state == S_IDLE))
    else $error("finished word not presented");
`endif

endmodule

// ----- hw/rtl/two_body_collision_step.sv -----
// Top level of the two-body collision stepper: configuration registers and units.
//
// Usage: each input word on item (item_valid / item_stall) is either a step, which
// advances both bodies by velocity times time_step and applies the restitution
// response when they are within collide_distance, or a load, which overwrites one
// body's position and velocity. Every accepted word yields exactly one result word
// on result (result_valid / result_stall) with the full state and the collided flag.
// Configuration is written on cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes are meant for when no word is in flight.
// A load goes straight to the finishing state. A step advances all four position
// components, then finishes if the bodies are far apart on one axis, or after the
// squared-distance check when there is no contact, and otherwise applies the collision.
// The collision path is set by the bit-serial centre-of-mass divider, which runs once
// per axis; the shared scale multiplier serves every product but the distance squares.
// One word is processed at a time; a new word is taken once the current one has
// reached the output register, while that register may still wait for the receiver.
// If the receiver stalls with a result pending, the next finished word holds inside
// the block until the register frees. Synchronous reset restores the default body
// state and register values and empties the output register.
module two_body_collision_step #(
  parameter int WORD_BITS     = tbcs_pkg::WORD_BITS_DEFAULT,
  parameter int FRACTION_BITS = tbcs_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  tbcs_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tbcs_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tbcs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import tbcs_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_MASS_ONE:         cfg.mass_one         <= cfg_data[MASS_BITS-1:0];
        REG_MASS_TWO:         cfg.mass_two         <= cfg_data[MASS_BITS-1:0];
        REG_TIME_STEP:        cfg.time_step        <= cfg_data[TS_BITS-1:0];
        REG_COLLIDE_DISTANCE: cfg.collide_distance <= cfg_data[DIST_BITS-1:0];
        REG_ELASTICITY:       cfg.elasticity       <= cfg_data[ELAS_BITS-1:0];
        default: ;
      endcase
    end
  end

  tbcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_func    (item.func),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tbcs_dp #(
    .WORD_BITS     (WORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .cfg    (cfg),
    .status (status),
    .result (result)
  );

endmodule

// ----- verif/tb_two_body_collision_step.sv -----
// Self-checking testbench for the two-body collision stepper.
`timescale 1ns / 1ps

module tb_two_body_collision_step;
  import tbcs_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam longint UNIT     = 64'sd1 <<< FRACTION_BITS_DEFAULT;
  localparam int     DRAIN_CYCLES = 140;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  item_t                     item = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  result_t                   result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Body state and register copy kept by the predictor, indexed [body][axis]
  longint    body_pos [2][2];
  longint    body_vel [2][2];
  cfg_t      model_cfg;
  result_t   expected_states [$];
  int        error_count = 0;
  int        items_sent = 0;
  int        sender_gap_pct = 0;
  int        receiver_stall_pct = 0;

  two_body_collision_step i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_word(longint a);
    if (a > WORD_MAX) return WORD_MAX;
    if (a < WORD_MIN) return WORD_MIN;
    return a;
  endfunction

  // Multiply by an unsigned Q0.16 factor, round half up
  function automatic longint scale_q16(longint a, longint q);
    return (a * q + ROUND_HALF) >>> REG_FRAC;
  endfunction

  // Mass-weighted mean velocity, nearest with ties away from zero
  function automatic longint mass_centre(longint va, longint vb, longint ma, longint mb);
    longint num;
    longint den;
    longint m;
    longint q;
    num = ma * va + mb * vb;
    den = ma + mb;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic bit bodies_touch();
    longint d;
    longint ax;
    longint ay;
    d = longint'(model_cfg.collide_distance);
    ax = body_pos[0][0] - body_pos[1][0];
    ay = body_pos[0][1] - body_pos[1][1];
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (ax > d || ay > d) return 1'b0;
    return (ax * ax + ay * ay <= d * d);
  endfunction

  function automatic void reset_bodies();
    body_pos[0][0] = -POS_RESET_MAG * UNIT;
    body_pos[0][1] = POS_RESET_MAG * UNIT;
    body_pos[1][0] = POS_RESET_MAG * UNIT;
    body_pos[1][1] = POS_RESET_MAG * UNIT;
    body_vel[0][0] = VEL_RESET_MAG * UNIT;
    body_vel[0][1] = -VEL_RESET_MAG * UNIT;
    body_vel[1][0] = -VEL_RESET_MAG * UNIT;
    body_vel[1][1] = -VEL_RESET_MAG * UNIT;
    model_cfg = CFG_RESET;
  endfunction

  // Apply one word to the body state and return the state word it yields
  function automatic result_t advance_bodies(item_t w);
    result_t r;
    longint  ma;
    longint  mb;
    longint  e;
    longint  vcm;
    longint  rel;
    int      b;
    logic    hit;
    hit = 1'b0;
    if (w.func == FUNC_LOAD) begin
      b = int'(w.body_select);
      body_pos[b][0] = longint'($signed(w.load_pos_x));
      body_pos[b][1] = longint'($signed(w.load_pos_y));
      body_vel[b][0] = longint'($signed(w.load_vel_x));
      body_vel[b][1] = longint'($signed(w.load_vel_y));
    end else begin
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 2; k++) begin
          body_pos[k][a] = clamp_word(body_pos[k][a] +
                                      scale_q16(body_vel[k][a], longint'(model_cfg.time_step)));
        end
      end
      if (bodies_touch()) begin
        ma = (model_cfg.mass_one == 0) ? 1 : longint'(model_cfg.mass_one);
        mb = (model_cfg.mass_two == 0) ? 1 : longint'(model_cfg.mass_two);
        e = (model_cfg.elasticity > E_ONE) ? longint'(E_ONE) : longint'(model_cfg.elasticity);
        for (int a = 0; a < 2; a++) begin
          vcm = mass_centre(body_vel[0][a], body_vel[1][a], ma, mb);
          for (int k = 0; k < 2; k++) begin
            rel = clamp_word(body_vel[k][a] - vcm);
            body_vel[k][a] = clamp_word(vcm - scale_q16(rel, e));
          end
        end
        hit = 1'b1;
      end
    end
    r.first_pos_x  = 32'(body_pos[0][0]);
    r.first_pos_y  = 32'(body_pos[0][1]);
    r.second_pos_x = 32'(body_pos[1][0]);
    r.second_pos_y = 32'(body_pos[1][1]);
    r.first_vel_x  = 32'(body_vel[0][0]);
    r.first_vel_y  = 32'(body_vel[0][1]);
    r.second_vel_x = 32'(body_vel[1][0]);
    r.second_vel_y = 32'(body_vel[1][1]);
    r.collided     = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %08h, want %08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_states.size() == 0) begin
        report_mismatch("result with none pending", result.first_pos_x, '0);
      end else begin
        want = expected_states.pop_front();
        if (result.first_pos_x !== want.first_pos_x)
          report_mismatch("first_pos_x", result.first_pos_x, want.first_pos_x);
        if (result.first_pos_y !== want.first_pos_y)
          report_mismatch("first_pos_y", result.first_pos_y, want.first_pos_y);
        if (result.second_pos_x !== want.second_pos_x)
          report_mismatch("second_pos_x", result.second_pos_x, want.second_pos_x);
        if (result.second_pos_y !== want.second_pos_y)
          report_mismatch("second_pos_y", result.second_pos_y, want.second_pos_y);
        if (result.first_vel_x !== want.first_vel_x)
          report_mismatch("first_vel_x", result.first_vel_x, want.first_vel_x);
        if (result.first_vel_y !== want.first_vel_y)
          report_mismatch("first_vel_y", result.first_vel_y, want.first_vel_y);
        if (result.second_vel_x !== want.second_vel_x)
          report_mismatch("second_vel_x", result.second_vel_x, want.second_vel_x);
        if (result.second_vel_y !== want.second_vel_y)
          report_mismatch("second_vel_y", result.second_vel_y, want.second_vel_y);
        if (result.collided !== want.collided)
          report_mismatch("collided", 32'(result.collided), 32'(want.collided));
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // ---------------------------------------------------------------- drivers

  // Offer one word, idling first at random, and predict it once taken
  task automatic send_word(item_t w);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (item_stall);
    expected_states.push_back(advance_bodies(w));
    items_sent++;
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MASS_ONE:         model_cfg.mass_one = value[MASS_BITS-1:0];
      REG_MASS_TWO:         model_cfg.mass_two = value[MASS_BITS-1:0];
      REG_TIME_STEP:        model_cfg.time_step = value[TS_BITS-1:0];
      REG_COLLIDE_DISTANCE: model_cfg.collide_distance = value[DIST_BITS-1:0];
      REG_ELASTICITY:       model_cfg.elasticity = value[ELAS_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_body(logic body, longint px, longint py, longint vx, longint vy);
    item_t w;
    w.func = FUNC_LOAD;
    w.body_select = body;
    w.load_pos_x = 32'(px);
    w.load_pos_y = 32'(py);
    w.load_vel_x = 32'(vx);
    w.load_vel_y = 32'(vy);
    send_word(w);
  endtask

  // Step word; the load fields and body select carry random noise
  task automatic step_bodies();
    item_t w;
    w.func = FUNC_STEP;
    w.body_select = 1'($urandom_range(1));
    w.load_pos_x = $urandom;
    w.load_pos_y = $urandom;
    w.load_vel_x = $urandom;
    w.load_vel_y = $urandom;
    send_word(w);
  endtask

  // Signed value whose magnitude spans a random number of bits
  function automatic longint spread_value(int min_shift);
    return longint'($signed($urandom)) >>> $urandom_range(min_shift, 31);
  endfunction

  task automatic randomize_registers();
    logic [CFG_DATA_BITS-1:0] reach;
    logic [CFG_DATA_BITS-1:0] elas;
    logic [CFG_DATA_BITS-1:0] dt;
    reach = ($urandom_range(3) == 0) ? CFG_DATA_BITS'($urandom)
                                     : CFG_DATA_BITS'($urandom_range(0, 1 << 20));
    elas = ($urandom_range(3) == 0) ? CFG_DATA_BITS'($urandom_range(0, 131071))
                                    : CFG_DATA_BITS'($urandom_range(0, 65536));
    dt = ($urandom_range(2) == 0) ? CFG_DATA_BITS'($urandom_range(0, 65535))
                                  : CFG_DATA_BITS'($urandom_range(0, 4000));
    write_register(REG_MASS_ONE, CFG_DATA_BITS'($urandom_range(0, 1023)));
    write_register(REG_MASS_TWO, CFG_DATA_BITS'($urandom_range(0, 1023)));
    write_register(REG_TIME_STEP, dt);
    write_register(REG_COLLIDE_DISTANCE, reach);
    write_register(REG_ELASTICITY, elas);
  endtask

  // Place two bodies near each other and step them through the encounter
  task automatic run_encounter();
    longint span;
    longint bx;
    longint by;
    int     steps;
    span = longint'(model_cfg.collide_distance) + 16;
    if (span > (64'sd1 << 30)) span = 64'sd1 << 30;
    bx = spread_value(1);
    by = spread_value(1);
    steps = $urandom_range(2, 10);
    load_body(1'b0, bx, by, spread_value(6), spread_value(6));
    load_body(1'b1,
              clamp_word(bx + longint'($urandom_range(0, 32'(2 * span))) - span),
              clamp_word(by + longint'($urandom_range(0, 32'(2 * span))) - span),
              spread_value(6), spread_value(6));
    repeat (steps) step_bodies();
  endtask

  task automatic send_noise();
    item_t w;
    w.func = 1'($urandom_range(1));
    w.body_select = 1'($urandom_range(1));
    w.load_pos_x = $urandom;
    w.load_pos_y = $urandom;
    w.load_vel_x = $urandom;
    w.load_vel_y = $urandom;
    send_word(w);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset state, saturation, repeated contact and distance boundaries
  task automatic test_directed_items();
    step_bodies();
    load_body(1'b0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    load_body(1'b1, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    step_bodies();
    // head-on approach, fires again while still close
    load_body(1'b0, 0, 0, 5 * UNIT, 0);
    load_body(1'b1, UNIT / 4, 0, -5 * UNIT, 0);
    step_bodies();
    step_bodies();
    // bodies at rest on and around the squared threshold
    load_body(1'b0, 0, 0, 0, 0);
    load_body(1'b1, 19661, 0, 0, 0);
    step_bodies();
    load_body(1'b1, 19662, 0, 0, 0);
    step_bodies();
    load_body(1'b1, 14000, 14000, 0, 0);
    step_bodies();
    load_body(1'b1, 13900, -13900, 0, 0);
    step_bodies();
    wait_drained();
  endtask

  // Register extremes: zero masses, elasticity above one and zero, reach limits
  task automatic test_register_extremes();
    write_register(REG_MASS_ONE, '0);
    write_register(REG_MASS_TWO, 1023);
    write_register(REG_TIME_STEP, '0);
    write_register(REG_COLLIDE_DISTANCE, 31'h7FFF_FFFF);
    write_register(REG_ELASTICITY, 131071);
    load_body(1'b0, 0, 0, WORD_MAX, WORD_MIN);
    load_body(1'b1, 0, 0, WORD_MIN, WORD_MAX);
    step_bodies();
    step_bodies();
    load_body(1'b0, WORD_MAX, WORD_MAX, 0, 0);
    load_body(1'b1, WORD_MIN, WORD_MIN, 0, 0);
    step_bodies();
    wait_drained();
    write_register(REG_MASS_ONE, 1023);
    write_register(REG_MASS_TWO, '0);
    write_register(REG_TIME_STEP, 65535);
    write_register(REG_COLLIDE_DISTANCE, '0);
    write_register(REG_ELASTICITY, '0);
    load_body(1'b0, 5 * UNIT, -3 * UNIT, UNIT, 2 * UNIT);
    load_body(1'b1, 5 * UNIT, -3 * UNIT, UNIT, 2 * UNIT);
    step_bodies();
    load_body(1'b1, 5 * UNIT, -3 * UNIT, -UNIT, 3 * UNIT);
    step_bodies();
    wait_drained();
  endtask

  // Mostly encounters, some noise; new registers after each drained chunk
  task automatic test_random_traffic(int gap_pct, int stall_pct, int count);
    int start;
    int chunk_start;
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < count) begin
      randomize_registers();
      chunk_start = items_sent;
      while (items_sent - chunk_start < 100 && items_sent - start < count) begin
        if ($urandom_range(99) < 80) run_encounter();
        else send_noise();
      end
      wait_drained();
    end
  endtask

  initial begin
    reset_bodies();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_items();
    test_register_extremes();
    test_random_traffic(10, 82, 410);
    test_random_traffic(82, 10, 410);
    test_random_traffic(0, 0, 410);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_two_body_collision_step: clean");
    end else begin
      $display("tb_two_body_collision_step: errors");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #25ms;
    $display("tb_two_body_collision_step: errors");
    $finish;
  end

endmodule
